// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file of this block.
// Both macros sample on aclk and stay quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge outside reset
`define CHK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("port check failed");

// Condition that must never be seen outside reset
`define CHK_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("forbidden port condition seen");

`endif

// ===== hw/rtl/dtl_pkg.sv =====
// Shared types and constants of the dirty tilemap layer scan block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dtl_pkg;

    // field widths
    localparam int REQ_W      = 2;
    localparam int LAYER_W    = 2;
    localparam int POS_W      = 7;
    localparam int SIZE_W     = 7;
    localparam int TILE_W     = 8;
    localparam int SCROLL_W   = 12;
    localparam int DIM_W      = 7;
    localparam int LCNT_W     = 3;
    localparam int SRC_W      = 13;
    localparam int DEST_W     = 11;
    localparam int COORD_W    = 13;   // signed map coordinate during address math

    // port widths
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // parameter defaults
    localparam int DEF_TILE_WIDTH  = 32;
    localparam int DEF_TILE_HEIGHT = 32;
    localparam int DEF_MAP_DIM     = 64;
    localparam int DEF_MAX_LAYERS  = 4;

    // register reset values
    localparam logic [DIM_W-1:0]  RST_MAP_COLS    = 7'd64;
    localparam logic [DIM_W-1:0]  RST_MAP_ROWS    = 7'd64;
    localparam logic [LCNT_W-1:0] RST_LAYER_COUNT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd4;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_MARK  = 2'd1,
        REQ_VISIT = 2'd2
    } req_t;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [LAYER_W-1:0]       layer;
        logic signed [POS_W-1:0]  col;
        logic signed [POS_W-1:0]  row;
        logic [SIZE_W-1:0]        rect_w;
        logic [SIZE_W-1:0]        rect_h;
        logic [TILE_W-1:0]        tile_value;
    } item_t;

    typedef struct packed {
        logic                     status;
        logic                     draw;
        logic [SRC_W-1:0]         src_x;
        logic signed [DEST_W-1:0] dest_x;
        logic signed [DEST_W-1:0] dest_y;
    } result_t;

    // map geometry registers seen by the engine
    typedef struct packed {
        logic [DIM_W-1:0]  map_cols;
        logic [DIM_W-1:0]  map_rows;
        logic [LCNT_W-1:0] layer_count;
    } geom_t;

endpackage

// ===== hw/rtl/dtl_div.sv =====
// Divider of a signed scroll offset by a constant tile size.
// Truncating quotient and remainder by reciprocal multiplication. Uses dtl_pkg.
`timescale 1ns / 1ps

module dtl_div
    import dtl_pkg::*;
#(
    parameter int DIVISOR = DEF_TILE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [SCROLL_W-1:0]          dividend,
    output logic                                busy,
    output logic signed [SCROLL_W-1:0]          quo,
    output logic signed [$clog2(DIVISOR):0]     rem
);

    localparam int RBW = $clog2(DIVISOR) + 1;
    localparam int SH  = 2 * SCROLL_W;
    localparam int MW  = SH - $clog2(DIVISOR) + 1;
    localparam int PW  = SCROLL_W + MW;
    // floor(2^SH / DIVISOR): the estimate is the quotient or one below it
    localparam logic [MW-1:0] RECIP = MW'((1 << SH) / DIVISOR);

    logic [SCROLL_W-1:0] mag_reg;
    logic                neg_reg;
    logic [SCROLL_W-1:0] qe_reg;
    logic [SCROLL_W-1:0] r_reg;
    logic [2:0]          stage_reg;
    logic signed [SCROLL_W-1:0] quo_reg;
    logic signed [RBW-1:0]      rem_reg;

    logic [PW-1:0]       prod;
    logic [SCROLL_W-1:0] qd;
    logic                ge;
    logic [SCROLL_W-1:0] q_fix;
    logic [SCROLL_W-1:0] r_fix;

    // quotient estimate, back product and one correction step
    always_comb begin
        prod  = PW'(mag_reg) * PW'(RECIP);
        qd    = SCROLL_W'(qe_reg * SCROLL_W'(DIVISOR));
        ge    = (r_reg >= SCROLL_W'(DIVISOR));
        q_fix = ge ? (qe_reg + 1'b1) : qe_reg;
        r_fix = ge ? (r_reg - SCROLL_W'(DIVISOR)) : r_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
        end else if (start) begin
            stage_reg <= 3'b001;
            neg_reg   <= dividend[SCROLL_W-1];
            mag_reg   <= dividend[SCROLL_W-1] ? (~dividend + 1'b1) : dividend;
        end else begin
            stage_reg <= {stage_reg[1:0], 1'b0};
            if (stage_reg[0]) begin
                qe_reg <= SCROLL_W'(prod >> SH);
            end
            if (stage_reg[1]) begin
                r_reg <= mag_reg - qd;
            end
            // last step: apply the sign of the dividend to both results
            if (stage_reg[2]) begin
                quo_reg <= neg_reg ? (~q_fix + 1'b1) : q_fix;
                rem_reg <= neg_reg ? (~RBW'(r_fix) + 1'b1) : RBW'(r_fix);
            end
        end
    end

    assign busy = |stage_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/dtl_engine.sv =====
// Request sequencer with the dirty count memory and the layer tile memory.
// Clears the dirty memory after reset, then runs one word at a time. Uses dtl_pkg.
`timescale 1ns / 1ps

module dtl_engine
    import dtl_pkg::*;
#(
    parameter int TILE_WIDTH  = DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT = DEF_TILE_HEIGHT,
    parameter int MAP_DIM     = DEF_MAP_DIM,
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  item_valid,
    input  item_t                                 item,
    output logic                                  in_ready,
    input  geom_t                                 geom,
    input  logic signed [SCROLL_W-1:0]            qx,
    input  logic signed [SCROLL_W-1:0]            qy,
    input  logic signed [$clog2(TILE_WIDTH):0]    rx,
    input  logic signed [$clog2(TILE_HEIGHT):0]   ry,
    input  logic                                  out_free,
    output logic                                  res_valid,
    output result_t                               res
);

    localparam int PLANE      = MAP_DIM * MAP_DIM;
    localparam int AW         = $clog2(PLANE);
    localparam int TILE_DEPTH = MAX_LAYERS * PLANE;
    localparam int TAW        = $clog2(TILE_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MARK,
        ST_VISIT_WB,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [AW-1:0] clr_cnt_reg;
    item_t   item_reg;
    result_t res_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, x_end_reg, y_end_reg;
    logic [AW-1:0] addr_reg;
    logic          inb_reg;
    logic          layer_ok_reg;

    // memories and their read data
    logic [LCNT_W-1:0] dirty_mem [PLANE];
    logic [TILE_W-1:0] tile_mem  [TILE_DEPTH];
    logic [LCNT_W-1:0] dirty_rd_reg;
    logic [TILE_W-1:0] tile_rd_reg;

    logic [DIM_W-1:0] eff_cols, eff_rows;
    logic signed [COORD_W-1:0] col_x, row_x, tx, ty;
    logic          layer_ok;
    logic          load_in, visit_in, mark_in;
    logic [AW-1:0] load_addr, visit_addr, mark_addr;
    logic [TAW-1:0] tile_base;
    logic          rect_empty;

    logic              dirty_we;
    logic [AW-1:0]     dirty_waddr;
    logic [LCNT_W-1:0] dirty_wdata;
    logic              dirty_rd_en;
    logic              tile_we;
    logic              tile_rd_en;

    logic              hit;
    logic [TILE_W-1:0] tile_eff;
    result_t           visit_res;

    // tile (c, r) inside the current map
    function automatic logic in_map_f(input logic signed [COORD_W-1:0] c,
                                      input logic signed [COORD_W-1:0] r,
                                      input logic [DIM_W-1:0] ec,
                                      input logic [DIM_W-1:0] er);
        return !c[COORD_W-1] && !r[COORD_W-1] &&
               (c[COORD_W-2:0] < (COORD_W-1)'(ec)) &&
               (r[COORD_W-2:0] < (COORD_W-1)'(er));
    endfunction

    // row-major address with the live map width
    function automatic logic [AW-1:0] addr_f(input logic signed [COORD_W-1:0] c,
                                             input logic signed [COORD_W-1:0] r,
                                             input logic [DIM_W-1:0] ec);
        logic [2*DIM_W-1:0] prod;
        logic [2*DIM_W:0]   sum;
        prod = r[DIM_W-1:0] * ec;
        sum  = {1'b0, prod} + (2*DIM_W+1)'(c[DIM_W-1:0]);
        return AW'(sum);
    endfunction

    // map size saturates at the memory's dimension
    assign eff_cols = (int'(geom.map_cols) > MAP_DIM) ? DIM_W'(MAP_DIM) : geom.map_cols;
    assign eff_rows = (int'(geom.map_rows) > MAP_DIM) ? DIM_W'(MAP_DIM) : geom.map_rows;

    // coordinates of the held word
    assign col_x = {{(COORD_W-POS_W){item_reg.col[POS_W-1]}}, item_reg.col};
    assign row_x = {{(COORD_W-POS_W){item_reg.row[POS_W-1]}}, item_reg.row};
    assign tx    = col_x + {{(COORD_W-SCROLL_W){qx[SCROLL_W-1]}}, qx};
    assign ty    = row_x + {{(COORD_W-SCROLL_W){qy[SCROLL_W-1]}}, qy};

    assign layer_ok   = (int'(item_reg.layer) < MAX_LAYERS);
    assign load_in    = in_map_f(col_x, row_x, eff_cols, eff_rows);
    assign visit_in   = in_map_f(tx, ty, eff_cols, eff_rows);
    assign mark_in    = in_map_f(x_reg, y_reg, eff_cols, eff_rows);
    assign load_addr  = addr_f(col_x, row_x, eff_cols);
    assign visit_addr = addr_f(tx, ty, eff_cols);
    assign mark_addr  = addr_f(x_reg, y_reg, eff_cols);
    assign tile_base  = TAW'(int'(item_reg.layer) * PLANE);
    assign rect_empty = (item_reg.rect_w == '0) || (item_reg.rect_h == '0);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(PLANE - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (item_valid) begin
                        item_reg  <= item;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (req_t'(item_reg.req_type))
                        REQ_MARK: begin
                            if (rect_empty) begin
                                // error answer: status set, all else zero
                                res_reg   <= result_t'({1'b1, (SRC_W + 2*DEST_W + 1)'(0)});
                                state_reg <= ST_DONE;
                            end else begin
                                res_reg   <= '0;
                                x_reg     <= col_x;
                                y_reg     <= row_x;
                                x_end_reg <= col_x + COORD_W'(item_reg.rect_w);
                                y_end_reg <= row_x + COORD_W'(item_reg.rect_h);
                                state_reg <= ST_MARK;
                            end
                        end
                        REQ_VISIT: begin
                            inb_reg      <= visit_in;
                            addr_reg     <= visit_addr;
                            layer_ok_reg <= layer_ok;
                            state_reg    <= ST_VISIT_WB;
                        end
                        default: begin
                            // loads write this cycle; unused kinds just answer
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_MARK: begin
                    // column-major walk, one tile a cycle
                    if (y_reg + COORD_W'(1) == y_end_reg) begin
                        y_reg <= row_x;
                        x_reg <= x_reg + COORD_W'(1);
                        if (x_reg + COORD_W'(1) == x_end_reg) begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        y_reg <= y_reg + COORD_W'(1);
                    end
                end
                ST_VISIT_WB: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // dirty memory port control; accesses never overlap since words run one at a time
    always_comb begin
        dirty_we    = 1'b0;
        dirty_waddr = addr_reg;
        dirty_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                dirty_we    = 1'b1;
                dirty_waddr = clr_cnt_reg;
            end
            ST_MARK: begin
                dirty_we    = mark_in;
                dirty_waddr = mark_addr;
                dirty_wdata = geom.layer_count;
            end
            ST_VISIT_WB: begin
                dirty_we    = hit && out_free;
                dirty_wdata = dirty_rd_reg - 1'b1;
            end
            default: begin
                dirty_we = 1'b0;
            end
        endcase
    end

    assign dirty_rd_en = (state_reg == ST_EXEC) &&
                         (item_reg.req_type == REQ_VISIT);
    assign tile_rd_en  = dirty_rd_en;
    assign tile_we     = (state_reg == ST_EXEC) &&
                         (item_reg.req_type == REQ_LOAD) && layer_ok && load_in;

    // dirty count memory
    always_ff @(posedge aclk) begin
        if (dirty_we) begin
            dirty_mem[dirty_waddr] <= dirty_wdata;
        end
        if (dirty_rd_en) begin
            dirty_rd_reg <= dirty_mem[visit_addr];
        end
    end

    // layer tile memory
    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_mem[tile_base + TAW'(load_addr)] <= item_reg.tile_value;
        end
        if (tile_rd_en) begin
            tile_rd_reg <= tile_mem[tile_base + TAW'(visit_addr)];
        end
    end

    // blit command from the read data
    always_comb begin
        hit       = inb_reg && (dirty_rd_reg != '0);
        tile_eff  = layer_ok_reg ? tile_rd_reg : '0;
        visit_res = '0;
        if (hit && (tile_eff != '0)) begin
            visit_res.draw   = 1'b1;
            visit_res.src_x  = SRC_W'(int'(tile_eff) * TILE_WIDTH);
            visit_res.dest_x = DEST_W'(int'(item_reg.col) * TILE_WIDTH - int'(rx));
            visit_res.dest_y = DEST_W'(int'(item_reg.row) * TILE_HEIGHT - int'(ry));
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = out_free &&
                       ((state_reg == ST_VISIT_WB) || (state_reg == ST_DONE));
    assign res       = (state_reg == ST_VISIT_WB) ? visit_res : res_reg;

endmodule

// ===== hw/rtl/dirty_tilemap_layer_scan_top.sv =====
// Top level of the dirty tilemap layer scan block.
// Holds the configuration registers and the output register. Uses dtl_pkg,
// dtl_div and dtl_engine.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready with the request kind in s_tuser.
//   Loads write a tile into a layer, marks set the dirty count of a rectangle
//   to layer_count, visits turn a screen cell into a blit command when its
//   map tile is dirty and nonempty. Every word gives exactly one result word
//   on m_tvalid/m_tready.
//   Flow: loads and unused kinds run ST_EXEC then ST_DONE, visits ST_EXEC
//   then ST_VISIT_WB; a mark walks rect_w * rect_h tiles in ST_MARK (one tile a cycle
//   through the dirty memory write port) before ST_DONE. One word is in flight
//   at a time, so the next word is accepted in ST_IDLE after the result is registered.
//   A write of scroll_x or scroll_y starts a division by the tile
//   size (reciprocal multiply and one correction); s_tready stays low until it finishes.
//   Reset: aresetn low clears the configuration to its reset values; after
//   it the dirty memory is cleared, one entry a cycle, over all MAP_DIM*MAP_DIM
//   entries (4096 at the default), with s_tready low.
//   Stall: a result waits in the output register while m_tready is low; the
//   next word can be accepted and run up to its result in the meantime.
`timescale 1ns / 1ps

module dirty_tilemap_layer_scan_top
    import dtl_pkg::*;
#(
    parameter int TILE_WIDTH  = DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT = DEF_TILE_HEIGHT,
    parameter int MAP_DIM     = DEF_MAP_DIM,
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // layer[1:0], col[8:2], row[15:9], rect_w[22:16], rect_h[29:23],
    // tile_value[37:30], zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_W-1:0]   s_tuser,
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // src_x[12:0], dest_x[23:13], dest_y[34:24], zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    // status[0], draw[1]
    output logic [M_TUSER_W-1:0]   m_tuser,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int RXW = $clog2(TILE_WIDTH) + 1;
    localparam int RYW = $clog2(TILE_HEIGHT) + 1;

    logic [DIM_W-1:0]  map_cols_reg;
    logic [DIM_W-1:0]  map_rows_reg;
    logic [LCNT_W-1:0] layer_count_reg;
    geom_t             geom;

    logic                       start_x, start_y;
    logic                       busy_x, busy_y;
    logic signed [SCROLL_W-1:0] qx, qy;
    logic signed [RXW-1:0]      rx;
    logic signed [RYW-1:0]      ry;

    item_t   item;
    logic    eng_ready;
    logic    accept;
    logic    out_free;
    logic    res_valid;
    result_t res;

    logic    m_tvalid_reg;
    result_t m_res_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_cols_reg    <= RST_MAP_COLS;
            map_rows_reg    <= RST_MAP_ROWS;
            layer_count_reg <= RST_LAYER_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAP_COLS:    map_cols_reg    <= cfg_wdata[DIM_W-1:0];
                CFG_MAP_ROWS:    map_rows_reg    <= cfg_wdata[DIM_W-1:0];
                CFG_LAYER_COUNT: layer_count_reg <= cfg_wdata[LCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign geom.map_cols    = map_cols_reg;
    assign geom.map_rows    = map_rows_reg;
    assign geom.layer_count = layer_count_reg;

    // scroll offsets are kept only as quotient and remainder by the tile size
    assign start_x = cfg_wr_en && (cfg_index == CFG_SCROLL_X);
    assign start_y = cfg_wr_en && (cfg_index == CFG_SCROLL_Y);

    dtl_div #(.DIVISOR(TILE_WIDTH)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_x),
        .dividend (cfg_wdata[SCROLL_W-1:0]),
        .busy     (busy_x),
        .quo      (qx),
        .rem      (rx)
    );

    dtl_div #(.DIVISOR(TILE_HEIGHT)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_y),
        .dividend (cfg_wdata[SCROLL_W-1:0]),
        .busy     (busy_y),
        .quo      (qy),
        .rem      (ry)
    );

    // input word unpack
    assign item.req_type   = s_tuser[REQ_W-1:0];
    assign item.layer      = s_tdata[1:0];
    assign item.col        = s_tdata[8:2];
    assign item.row        = s_tdata[15:9];
    assign item.rect_w     = s_tdata[22:16];
    assign item.rect_h     = s_tdata[29:23];
    assign item.tile_value = s_tdata[37:30];

    assign s_tready = eng_ready && !busy_x && !busy_y && !cfg_wr_en;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    dtl_engine #(
        .TILE_WIDTH  (TILE_WIDTH),
        .TILE_HEIGHT (TILE_HEIGHT),
        .MAP_DIM     (MAP_DIM),
        .MAX_LAYERS  (MAX_LAYERS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .item       (item),
        .in_ready   (eng_ready),
        .geom       (geom),
        .qx         (qx),
        .qy         (qy),
        .rx         (rx),
        .ry         (ry),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
            m_res_reg    <= res;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - SRC_W - 2*DEST_W)'(0),
                       m_res_reg.dest_y, m_res_reg.dest_x, m_res_reg.src_x};
    assign m_tuser  = {m_res_reg.draw, m_res_reg.status};

endmodule

// ===== hw/rtl/dtl_checker.sv =====
// Port-level checks of the dirty tilemap layer scan block, bound to the top.
// Uses dtl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtl_checker
    import dtl_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser
);

    // a stalled result word stays offered and unchanged
    `CHK_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid)
    `CHK_ASSERT(a_word_holds, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))

    // no blit means an all-zero data word
    `CHK_ASSERT(a_idle_word_zero, m_tvalid && !m_tuser[1] |-> m_tdata == '0)

    // an error answer never carries a blit
    `CHK_NEVER(a_status_draw, m_tvalid && m_tuser[0] && m_tuser[1])

    // one word in flight: ready drops right after an accept
    `CHK_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready)

endmodule

bind dirty_tilemap_layer_scan_top dtl_checker u_dtl_checker (.*);
